// File: design/mfw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfw_pkg
// shared types and constants of the streaming median filter
// ----------------------------------------------------------------------------
package mfw_pkg;

  localparam int PIX_W      = 8;
  localparam int CFG_W      = 11;
  localparam int ROW_W      = 10;
  localparam int ADDR_W     = 4;
  localparam int DATA_W     = 32;
  localparam int MIN_DIM    = 5;
  localparam int MAX_HEIGHT = 1024;

  localparam logic [CFG_W-1:0] WIDTH_RST  = 11'd512;
  localparam logic [CFG_W-1:0] HEIGHT_RST = 11'd512;
  localparam logic             MODE_RST   = 1'b0;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_MODE   = 2'd2
  } cfg_reg_e;

  // side info that travels with each window word
  typedef struct packed {
    logic mode;
    logic last;
  } item_ctrl_t;

endpackage

// File: design/median_filter_window.sv
`timescale 1ns / 1ps
// a pushed word passes the front register, the window queue, back stages b1 and b2 and the result queue
// throughput: one pixel per cycle while full is low, set by one line store read and write per pixel
// border pixels are consumed without a result
// reset: counters at row 0 column 0, queues empty, registers at 512, 512, 3x3
// any valid configuration write restarts the frame at row 0 column 0
// ----------------------------------------------------------------------------
// median_filter_window
// streaming 3x3 / 5x5 median filter over raster gray pixels
// ----------------------------------------------------------------------------
module median_filter_window #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_RADIUS = 2
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic [mfw_pkg::PIX_W-1:0]     pixel_in_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [mfw_pkg::PIX_W-1:0]     median_out_o,
  output logic                          frame_last_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mfw_pkg::ADDR_W-1:0]    paddr,
  input  logic [mfw_pkg::DATA_W-1:0]    pwdata,
  output logic [mfw_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);

  localparam int SIDE      = 2*MAX_RADIUS+1;
  localparam int WIN_W     = SIDE*SIDE*mfw_pkg::PIX_W;
  localparam int CTRL_W    = $bits(mfw_pkg::item_ctrl_t);
  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 4;
  localparam int MCW       = $clog2(MID_DEPTH+1);
  localparam int OCW       = $clog2(OUT_DEPTH+1);
  localparam int CFG_W     = mfw_pkg::CFG_W;

  logic [CFG_W-1:0]  width_q, height_q;
  logic              mode_q;
  logic              cfg_wr, restart;
  mfw_pkg::cfg_reg_e cfg_idx;

  logic                 take;
  logic                 q_push;
  logic [WIN_W-1:0]     q_win;
  mfw_pkg::item_ctrl_t  q_ctrl;
  logic [WIN_W+CTRL_W-1:0] mid_rdata;
  logic                 mid_empty, mid_pop;
  logic [MCW-1:0]       mid_count;
  mfw_pkg::item_ctrl_t  mid_ctrl;

  logic                 out_push, out_last;
  logic [mfw_pkg::PIX_W-1:0] out_med;
  logic [mfw_pkg::PIX_W:0]   out_rdata;
  logic [OCW-1:0]       out_count;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = mfw_pkg::cfg_reg_e'(paddr[3:2]);

  always_comb begin
    restart = 1'b0;
    prdata  = '0;
    case (cfg_idx)
      mfw_pkg::REG_WIDTH: begin
        restart = cfg_wr;
        prdata  = mfw_pkg::DATA_W'(width_q);
      end
      mfw_pkg::REG_HEIGHT: begin
        restart = cfg_wr;
        prdata  = mfw_pkg::DATA_W'(height_q);
      end
      mfw_pkg::REG_MODE: begin
        restart = cfg_wr;
        prdata  = mfw_pkg::DATA_W'(mode_q);
      end
      default: begin
        restart = 1'b0;
        prdata  = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= mfw_pkg::WIDTH_RST;
      height_q <= mfw_pkg::HEIGHT_RST;
      mode_q   <= mfw_pkg::MODE_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        mfw_pkg::REG_WIDTH:  width_q  <= pwdata[CFG_W-1:0];
        mfw_pkg::REG_HEIGHT: height_q <= pwdata[CFG_W-1:0];
        mfw_pkg::REG_MODE:   mode_q   <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  // one slot held back for the word in the front's last stage
  assign full = (mid_count >= MCW'(MID_DEPTH-1));
  assign take = push && !full;

  mfw_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_RADIUS(MAX_RADIUS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .take_i        (take),
    .pixel_i       (pixel_in_i),
    .line_width_i  (width_q),
    .frame_height_i(height_q),
    .mode_i        (mode_q),
    .restart_i     (restart),
    .q_push_o      (q_push),
    .q_win_o       (q_win),
    .q_ctrl_o      (q_ctrl)
  );

  mfw_fifo #(
    .WIDTH(WIN_W+CTRL_W),
    .DEPTH(MID_DEPTH)
  ) u_mid_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .wdata_i({q_ctrl, q_win}),
    .pop_i  (mid_pop),
    .rdata_o(mid_rdata),
    .empty_o(mid_empty),
    .count_o(mid_count)
  );

  assign mid_ctrl = mfw_pkg::item_ctrl_t'(mid_rdata[WIN_W +: CTRL_W]);

  mfw_back #(
    .MAX_RADIUS(MAX_RADIUS),
    .OUT_DEPTH (OUT_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (!mid_empty),
    .in_win_i    (mid_rdata[WIN_W-1:0]),
    .in_ctrl_i   (mid_ctrl),
    .take_o      (mid_pop),
    .out_count_i (out_count),
    .out_push_o  (out_push),
    .out_median_o(out_med),
    .out_last_o  (out_last)
  );

  mfw_fifo #(
    .WIDTH(mfw_pkg::PIX_W+1),
    .DEPTH(OUT_DEPTH)
  ) u_out_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (out_push),
    .wdata_i({out_last, out_med}),
    .pop_i  (pop),
    .rdata_o(out_rdata),
    .empty_o(empty),
    .count_o(out_count)
  );

  assign median_out_o = out_rdata[mfw_pkg::PIX_W-1:0];
  assign frame_last_o = out_rdata[mfw_pkg::PIX_W];

endmodule

// File: design/mfw_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfw_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module mfw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/mfw_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfw_fifo
// small register queue with occupancy count
// ----------------------------------------------------------------------------
module mfw_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [WIDTH-1:0]           wdata_i,
  input  logic                       pop_i,
  output logic [WIDTH-1:0]           rdata_o,
  output logic                       empty_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wp_q, wp_d, rp_q, rp_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_pop;

  assign do_pop = pop_i && (cnt_q != '0);

  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wp_d = (wp_q == PW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
    end
    if (do_pop) begin
      rp_d = (rp_q == PW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= wdata_i;
    end
  end

  assign rdata_o = mem_q[rp_q];
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;

  ap_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !do_pop |-> cnt_q != CW'(DEPTH))
    else $error("queue written while full");

  ap_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !do_pop |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("queue count lost a word");

  ap_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == '0 |-> wp_q == rp_q)
    else $error("queue pointers disagree with empty count");

endmodule

// File: design/mfw_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfw_front
// raster counters, line stores and window shift; queues interior windows
// ----------------------------------------------------------------------------
module mfw_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_RADIUS = 2
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 take_i,
  input  logic [mfw_pkg::PIX_W-1:0]            pixel_i,
  input  logic [mfw_pkg::CFG_W-1:0]            line_width_i,
  input  logic [mfw_pkg::CFG_W-1:0]            frame_height_i,
  input  logic                                 mode_i,
  input  logic                                 restart_i,
  output logic                                 q_push_o,
  output logic [(2*MAX_RADIUS+1)*(2*MAX_RADIUS+1)*mfw_pkg::PIX_W-1:0] q_win_o,
  output mfw_pkg::item_ctrl_t                  q_ctrl_o
);

  localparam int SIDE  = 2*MAX_RADIUS+1;
  localparam int LINES = 2*MAX_RADIUS;
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int WW    = CW+1;
  localparam int PW    = mfw_pkg::PIX_W;
  localparam int RW    = mfw_pkg::ROW_W;
  localparam int HW    = mfw_pkg::CFG_W;

  logic [12:0]    lw_ext;
  logic [WW-1:0]  eff_w;
  logic [HW-1:0]  eff_h;
  logic [2:0]     two_rad;
  logic [WW-1:0]  c_inc;
  logic [HW-1:0]  r_inc;
  logic           produce, last;

  logic [CW-1:0]  c_q, c_d;
  logic [RW-1:0]  r_q, r_d;

  logic           s1_valid_q;
  logic [PW-1:0]  s1_pix_q;
  logic [CW-1:0]  s1_addr_q;
  logic           s1_prod_q, s1_last_q, s1_mode_q;

  logic [PW-1:0]  rd_data [LINES];
  logic [PW-1:0]  col [SIDE];
  logic [PW-1:0]  win_q [SIDE][SIDE];
  logic [PW-1:0]  win_d [SIDE][SIDE];

  // effective frame size, clamped
  always_comb begin
    lw_ext = 13'(line_width_i);
    if (lw_ext < 13'(mfw_pkg::MIN_DIM)) begin
      eff_w = WW'(mfw_pkg::MIN_DIM);
    end else if (lw_ext > 13'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(lw_ext);
    end
    if (frame_height_i < HW'(mfw_pkg::MIN_DIM)) begin
      eff_h = HW'(mfw_pkg::MIN_DIM);
    end else if (frame_height_i > HW'(mfw_pkg::MAX_HEIGHT)) begin
      eff_h = HW'(mfw_pkg::MAX_HEIGHT);
    end else begin
      eff_h = frame_height_i;
    end
  end

  always_comb begin
    two_rad = (mode_i && MAX_RADIUS > 1) ? 3'd4 : 3'd2;
    c_inc   = WW'(c_q) + 1'b1;
    r_inc   = HW'(r_q) + 1'b1;
    produce = (HW'(r_q) >= HW'(two_rad)) && (WW'(c_q) >= WW'(two_rad));
    last    = (r_inc >= eff_h) && (c_inc >= eff_w);
    c_d = c_q;
    r_d = r_q;
    if (restart_i) begin
      c_d = '0;
      r_d = '0;
    end else if (take_i) begin
      if (c_inc >= eff_w) begin
        c_d = '0;
        r_d = (r_inc >= eff_h) ? '0 : RW'(r_inc);
      end else begin
        c_d = CW'(c_inc);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_q        <= '0;
      r_q        <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      c_q        <= c_d;
      r_q        <= r_d;
      s1_valid_q <= take_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      s1_pix_q  <= pixel_i;
      s1_addr_q <= c_q;
      s1_prod_q <= produce;
      s1_last_q <= last;
      s1_mode_q <= mode_i;
    end
  end

  // window column: stored lines oldest first, then the new pixel
  always_comb begin
    for (int k = 0; k < LINES; k++) begin
      col[k] = rd_data[k];
    end
    col[LINES] = s1_pix_q;
    for (int y = 0; y < SIDE; y++) begin
      for (int x = 0; x < SIDE-1; x++) begin
        win_d[y][x] = win_q[y][x+1];
      end
      win_d[y][SIDE-1] = col[y];
    end
  end

  for (genvar k = 0; k < LINES; k++) begin : g_line
    mfw_ram #(
      .WIDTH(PW),
      .DEPTH(MAX_WIDTH)
    ) u_line (
      .clk_i  (clk_i),
      .we_i   (s1_valid_q),
      .waddr_i(s1_addr_q),
      .wdata_i(col[k+1]),
      .re_i   (take_i),
      .raddr_i(c_q),
      .rdata_o(rd_data[k])
    );
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      win_q <= win_d;
    end
  end

  for (genvar y = 0; y < SIDE; y++) begin : g_row
    for (genvar x = 0; x < SIDE; x++) begin : g_col
      assign q_win_o[(y*SIDE+x)*PW +: PW] = win_d[y][x];
    end
  end

  assign q_push_o      = s1_valid_q && s1_prod_q;
  assign q_ctrl_o.mode = s1_mode_q;
  assign q_ctrl_o.last = s1_last_q;

endmodule

// File: design/mfw_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfw_back
// two stage rank-count median over the queued window
// ----------------------------------------------------------------------------
module mfw_back #(
  parameter int MAX_RADIUS = 2,
  parameter int OUT_DEPTH  = 4
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  input  logic [(2*MAX_RADIUS+1)*(2*MAX_RADIUS+1)*mfw_pkg::PIX_W-1:0] in_win_i,
  input  mfw_pkg::item_ctrl_t                  in_ctrl_i,
  output logic                                 take_o,
  input  logic [$clog2(OUT_DEPTH+1)-1:0]       out_count_i,
  output logic                                 out_push_o,
  output logic [mfw_pkg::PIX_W-1:0]            out_median_o,
  output logic                                 out_last_o
);

  localparam int SIDE  = 2*MAX_RADIUS+1;
  localparam int CELLS = SIDE*SIDE;
  localparam int PW    = mfw_pkg::PIX_W;
  localparam int NW    = $clog2(CELLS+1);
  localparam int OCW   = $clog2(OUT_DEPTH+1);
  localparam logic [NW-1:0] MID_SMALL = NW'(4);
  localparam logic [NW-1:0] MID_LARGE = NW'((CELLS)/2);

  logic [PW-1:0]    v [CELLS];
  logic [CELLS-1:0] incl;
  logic [CELLS-1:0] lt_d [CELLS];
  logic             big;

  logic             b1_valid_q;
  logic [PW-1:0]    b1_v_q [CELLS];
  logic [CELLS-1:0] b1_incl_q;
  logic [CELLS-1:0] b1_lt_q [CELLS];
  logic [NW-1:0]    b1_target_q;
  logic             b1_last_q;

  logic             b2_valid_q;
  logic [PW-1:0]    b2_med_q, b2_med_d;
  logic             b2_last_q;
  logic [OCW+1:0]   in_flight;

  // keep the output queue from overflowing with words still in the pipe
  assign in_flight = (OCW+2)'(out_count_i) + (OCW+2)'(b1_valid_q) + (OCW+2)'(b2_valid_q);
  assign take_o    = in_valid_i && (in_flight < (OCW+2)'(OUT_DEPTH));

  always_comb begin
    big = in_ctrl_i.mode && (MAX_RADIUS > 1);
    for (int i = 0; i < CELLS; i++) begin
      v[i] = in_win_i[i*PW +: PW];
      // 3x3 uses the bottom right corner of the window
      incl[i] = big || ((i / SIDE) >= SIDE-3 && (i % SIDE) >= SIDE-3);
    end
    // tie break by position gives every included cell a distinct rank
    for (int i = 0; i < CELLS; i++) begin
      for (int j = 0; j < CELLS; j++) begin
        lt_d[i][j] = incl[j] && ((v[j] < v[i]) || ((v[j] == v[i]) && (j < i)));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_valid_q <= 1'b0;
      b2_valid_q <= 1'b0;
    end else begin
      b1_valid_q <= take_o;
      b2_valid_q <= b1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      b1_v_q      <= v;
      b1_incl_q   <= incl;
      b1_lt_q     <= lt_d;
      b1_target_q <= big ? MID_LARGE : MID_SMALL;
      b1_last_q   <= in_ctrl_i.last;
    end
  end

  always_comb begin
    b2_med_d = '0;
    for (int i = 0; i < CELLS; i++) begin
      if (b1_incl_q[i] && (NW'($countones(b1_lt_q[i])) == b1_target_q)) begin
        b2_med_d = b2_med_d | b1_v_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (b1_valid_q) begin
      b2_med_q  <= b2_med_d;
      b2_last_q <= b1_last_q;
    end
  end

  assign out_push_o   = b2_valid_q;
  assign out_median_o = b2_med_q;
  assign out_last_o   = b2_last_q;

endmodule

// File: test/median_filter_window_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// median_filter_window_tb
// Drives pixel frames in 3x3 and 5x5 mode through the queue ports and
// configures the block over its APB port. A behavioral median predictor
// with its own line stores and window runs alongside the block, and every
// popped word is compared with the oldest predicted word.
// ----------------------------------------------------------------------------
module median_filter_window_tb;

  localparam int PIX_W     = mfw_pkg::PIX_W;
  localparam int ADDR_W    = mfw_pkg::ADDR_W;
  localparam int DATA_W    = mfw_pkg::DATA_W;
  localparam int CFG_W     = mfw_pkg::CFG_W;
  localparam int MIN_DIM   = mfw_pkg::MIN_DIM;
  localparam int STORE_W   = 1024;
  localparam int MAX_CYC   = 600000;
  localparam int DRAIN_CYC = 12;

  typedef struct packed {
    logic [PIX_W-1:0] median;
    logic             last;
  } median_word_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                push = 1'b0;
  logic                full;
  logic [PIX_W-1:0]    pixel_in_i = '0;
  logic                empty;
  logic                pop = 1'b0;
  logic [PIX_W-1:0]    median_out_o;
  logic                frame_last_o;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  median_filter_window DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .push(push), .full(full), .pixel_in_i(pixel_in_i),
    .empty(empty), .pop(pop), .median_out_o(median_out_o), .frame_last_o(frame_last_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [PIX_W-1:0] line_mem [4][STORE_W];
  logic [PIX_W-1:0] win [5][5];
  int               col_pos, row_pos;
  logic [CFG_W-1:0] cfg_width, cfg_height;
  logic             cfg_mode;
  median_word_t     median_q[$];

  int  mismatches = 0;
  int  pixels_sent = 0;
  int  words_seen = 0;
  int  frames_done = 0;
  int  cycles = 0;
  bit  push_idle_en = 1'b1;
  bit  pop_idle_en = 1'b1;

  function automatic int clamp_dim(input logic [CFG_W-1:0] v);
    if (v < MIN_DIM) return MIN_DIM;
    if (v > 1024) return 1024;
    return int'(v);
  endfunction

  function automatic void restart_frame();
    col_pos = 0;
    row_pos = 0;
  endfunction

  function automatic logic [PIX_W-1:0] window_median(input int radius);
    logic [PIX_W-1:0] v [25];
    logic [PIX_W-1:0] x;
    int n, j, first;
    n = 0;
    first = 4 - 2 * radius;
    for (int r = first; r < 5; r++)
      for (int c = first; c < 5; c++) begin
        v[n] = win[r][c];
        n++;
      end
    for (int i = 1; i < n; i++) begin
      x = v[i];
      j = i;
      while (j > 0 && v[j-1] > x) begin
        v[j] = v[j-1];
        j--;
      end
      v[j] = x;
    end
    return v[n/2];
  endfunction

  // one accepted pixel: advance the window and queue a median for interior pixels
  function automatic void predict_pixel(input logic [PIX_W-1:0] pix);
    logic [PIX_W-1:0] colv [5];
    median_word_t     w;
    int wd, ht, radius, c;
    wd = clamp_dim(cfg_width);
    ht = clamp_dim(cfg_height);
    radius = cfg_mode ? 2 : 1;
    c = (col_pos >= STORE_W) ? STORE_W - 1 : col_pos;
    for (int k = 0; k < 4; k++) colv[k] = line_mem[k][c];
    colv[4] = pix;
    for (int y = 0; y < 5; y++) begin
      for (int x = 0; x < 4; x++) win[y][x] = win[y][x+1];
      win[y][4] = colv[y];
    end
    for (int k = 0; k < 3; k++) line_mem[k][c] = colv[k+1];
    line_mem[3][c] = pix;
    if (row_pos >= 2 * radius && c >= 2 * radius) begin
      w.median = window_median(radius);
      w.last = (row_pos + 1 >= ht) && (c + 1 >= wd);
      median_q.push_back(w);
    end
    c++;
    if (c >= wd) begin
      c = 0;
      row_pos++;
      if (row_pos >= ht) begin
        row_pos = 0;
        frames_done++;
      end
    end
    col_pos = c;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    median_word_t got, want;
    if (rst_ni && pop && !empty) begin
      got.median = median_out_o;
      got.last = frame_last_o;
      words_seen++;
      if (median_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: median %0d last %0b", got.median, got.last);
      end else begin
        want = median_q.pop_front();
        if (got.median !== want.median || got.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("word %0d mismatch: expected median %0d last %0b, got median %0d last %0b",
                     words_seen, want.median, want.last, got.median, got.last);
        end
      end
    end
  end

  always @(negedge clk_i)
    pop <= pop_idle_en ? ($urandom_range(99) >= 24) : 1'b1;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > MAX_CYC) begin
      $display("timeout after %0d cycles", cycles);
      $display("median_filter_window_tb NOT OK");
      $finish;
    end
  end

  task automatic send_pixel(input logic [PIX_W-1:0] pix);
    if (push_idle_en && $urandom_range(99) < 24) begin
      @(negedge clk_i);
      push = 1'b0;
      repeat ($urandom_range(2)) @(negedge clk_i);
    end else begin
      @(negedge clk_i);
    end
    push = 1'b1;
    pixel_in_i = pix;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    predict_pixel(pix);
    pixels_sent++;
  endtask

  // let in-flight words land before touching the registers
  task automatic wait_idle();
    @(negedge clk_i);
    push = 1'b0;
    while (median_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
  endtask

  task automatic apb_read_check(input mfw_pkg::cfg_reg_e idx, input logic [DATA_W-1:0] want);
    @(negedge clk_i);
    psel = 1'b1; pwrite = 1'b0; paddr = ADDR_W'({idx, 2'b00});
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("register %s read: expected %0d, got %0d", idx.name(), want, prdata);
    end
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0;
  endtask

  task automatic write_reg(input mfw_pkg::cfg_reg_e idx, input logic [DATA_W-1:0] val);
    logic [DATA_W-1:0] stored;
    wait_idle();
    @(negedge clk_i);
    psel = 1'b1; pwrite = 1'b1; paddr = ADDR_W'({idx, 2'b00}); pwdata = val;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      mfw_pkg::REG_WIDTH: begin
        cfg_width = val[CFG_W-1:0];
        stored = DATA_W'(cfg_width);
      end
      mfw_pkg::REG_HEIGHT: begin
        cfg_height = val[CFG_W-1:0];
        stored = DATA_W'(cfg_height);
      end
      default: begin
        cfg_mode = val[0];
        stored = DATA_W'(cfg_mode);
      end
    endcase
    restart_frame();
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    apb_read_check(idx, stored);
  endtask

  task automatic setup_frame(input int wd, input int ht, input logic mode);
    write_reg(mfw_pkg::REG_WIDTH, DATA_W'(wd));
    write_reg(mfw_pkg::REG_HEIGHT, DATA_W'(ht));
    write_reg(mfw_pkg::REG_MODE, DATA_W'(mode));
  endtask

  task automatic send_frame(input int npix, input int lo, input int hi);
    for (int i = 0; i < npix; i++) send_pixel(PIX_W'($urandom_range(hi, lo)));
  endtask

  task automatic test_reset_values();
    apb_read_check(mfw_pkg::REG_WIDTH, DATA_W'(mfw_pkg::WIDTH_RST));
    apb_read_check(mfw_pkg::REG_HEIGHT, DATA_W'(mfw_pkg::HEIGHT_RST));
    apb_read_check(mfw_pkg::REG_MODE, DATA_W'(mfw_pkg::MODE_RST));
  endtask

  // 5x5 frame with extreme values in 3x3 mode, then the same shape in 5x5
  task automatic test_small_frames();
    setup_frame(5, 5, 1'b0);
    for (int i = 0; i < 25; i++)
      send_pixel((i % 3 == 0) ? 8'hFF : ((i % 3 == 1) ? 8'h00 : PIX_W'(i * 37)));
    write_reg(mfw_pkg::REG_MODE, 1);
    for (int i = 0; i < 25; i++) send_pixel(PIX_W'(8'hAA ^ (i * 11)));
  endtask

  // register values outside the usable range are clamped
  task automatic test_clamped_sizes();
    setup_frame(0, 3, 1'b1);
    send_frame(25, 0, 255);
    // wide rows: only the first row goes in, so no window completes
    setup_frame(2047, 4, 1'b0);
    send_frame(16, 0, 255);
    // tall frame: rows well past five still carry no frame end
    setup_frame(6, 2047, 1'b1);
    send_frame(6 * 8, 0, 255);
  endtask

  // a register write in the middle of a frame restarts it
  task automatic test_mid_frame_restart();
    setup_frame(7, 6, 1'b0);
    send_frame(23, 0, 255);
    write_reg(mfw_pkg::REG_MODE, 1);
    send_frame(7 * 6, 0, 255);
  endtask

  task automatic test_random_frames();
    int wd, ht, target;
    logic mode;
    target = pixels_sent + 1350;
    for (int f = 0; pixels_sent < target; f++) begin
      // a run of frames with both sides always ready
      push_idle_en = !(f >= 6 && f < 10);
      pop_idle_en = push_idle_en;
      wd = $urandom_range(16, 5);
      ht = $urandom_range(10, 5);
      mode = $urandom_range(1);
      setup_frame(wd, ht, mode);
      if ($urandom_range(9) == 0)
        send_frame($urandom_range(wd * ht - 1, 1), 0, 255);
      else if ($urandom_range(3) == 0)
        send_frame(wd * ht, 100, 103);
      else
        send_frame(wd * ht * $urandom_range(2, 1), 0, 255);
    end
    push_idle_en = 1'b1;
    pop_idle_en = 1'b1;
  endtask

  initial begin
    cfg_width = mfw_pkg::WIDTH_RST;
    cfg_height = mfw_pkg::HEIGHT_RST;
    cfg_mode = mfw_pkg::MODE_RST;
    restart_frame();
    for (int k = 0; k < 4; k++)
      for (int c = 0; c < STORE_W; c++) line_mem[k][c] = '0;
    for (int y = 0; y < 5; y++)
      for (int x = 0; x < 5; x++) win[y][x] = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_values();
    test_small_frames();
    test_clamped_sizes();
    test_mid_frame_restart();
    test_random_frames();

    wait_idle();
    if (median_q.size() != 0) mismatches += median_q.size();
    $display("pixels pushed: %0d, medians checked: %0d, whole frames: %0d",
             pixels_sent, words_seen, frames_done);
    $display("covered 3x3 and 5x5 windows, clamped sizes, restarts and random stalls");
    if (mismatches == 0) begin
      $display("median_filter_window_tb OK");
    end else begin
      $display("mismatches: %0d", mismatches);
      $display("median_filter_window_tb NOT OK");
    end
    $finish;
  end

endmodule
